[rtl/pcma_pkg.sv]
// ----------------------------------------------------------------------------
// pcma_pkg
// Shared types, widths and constants of the PID / clamp / moving-average core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcma_pkg;

    // ring depth and derived widths
    localparam int MAX_WINDOW = 16;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = 32 + IDX_W;

    // radix-16 restoring divider: four quotient bits per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYC    = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W      = DIV_CYC * DIV_STEPS;
    localparam int DIV_CNT_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    localparam logic [31:0] INT32_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN  = 32'h8000_0000;
    localparam logic [47:0] INT48_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] INT48_MIN  = 48'h8000_0000_0000;
    localparam logic [63:0] TERM_LIMIT = 64'h1000_0000_0000_0000;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SETPOINT      = 4'd0,
        REG_KP            = 4'd1,
        REG_KI_SCALED     = 4'd2,
        REG_KD_SCALED     = 4'd3,
        REG_OUTPUT_OFFSET = 4'd4,
        REG_CLAMP_HI      = 4'd5,
        REG_CLAMP_LO      = 4'd6,
        REG_WINDOW_LENGTH = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] setpoint;
        logic signed [31:0] kp;
        logic signed [31:0] ki_scaled;
        logic signed [31:0] kd_scaled;
        logic signed [31:0] output_offset;
        logic signed [31:0] clamp_hi;
        logic signed [31:0] clamp_lo;
        logic        [4:0]  window_length;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_INTEG,
        ST_OPND,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MAG,
        ST_ACC,
        ST_CLAMP,
        ST_WRITE,
        ST_SUM,
        ST_DIV_SET,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } term_t;

    typedef struct packed {
        logic  capture;
        logic  calc_err;
        logic  calc_integ;
        logic  load_opnd;
        logic  mul_lo;
        logic  mul_hi;
        logic  calc_mag;
        logic  accum;
        term_t term;
        logic  clamp;
        logic  ring_write;
        logic  sum_step;
        logic  div_set;
        logic  div_step;
        logic  load_out;
    } cmd_t;

    typedef struct packed {
        logic sum_last;
        logic div_last;
    } sts_t;

endpackage

`default_nettype wire

[rtl/pcma_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pcma_cfg_regs
// Configuration register file, write-only, with reset defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pcma_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [pcma_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [pcma_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output pcma_pkg::cfg_t                         cfg
);

    pcma_pkg::cfg_t cfg_reg;
    pcma_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                pcma_pkg::REG_SETPOINT:      cfg_next.setpoint      = cfg_wdata;
                pcma_pkg::REG_KP:            cfg_next.kp            = cfg_wdata;
                pcma_pkg::REG_KI_SCALED:     cfg_next.ki_scaled     = cfg_wdata;
                pcma_pkg::REG_KD_SCALED:     cfg_next.kd_scaled     = cfg_wdata;
                pcma_pkg::REG_OUTPUT_OFFSET: cfg_next.output_offset = cfg_wdata;
                pcma_pkg::REG_CLAMP_HI:      cfg_next.clamp_hi      = cfg_wdata;
                pcma_pkg::REG_CLAMP_LO:      cfg_next.clamp_lo      = cfg_wdata;
                pcma_pkg::REG_WINDOW_LENGTH: cfg_next.window_length = cfg_wdata[4:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint      <= 32'sd0;
            cfg_reg.kp            <= 32'sd655;
            cfg_reg.ki_scaled     <= 32'sd0;
            cfg_reg.kd_scaled     <= 32'sd6554;
            cfg_reg.output_offset <= 32'sd0;
            cfg_reg.clamp_hi      <= 32'sd1311;
            cfg_reg.clamp_lo      <= -32'sd1311;
            cfg_reg.window_length <= 5'd10;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/pcma_ctrl.sv]
// ----------------------------------------------------------------------------
// pcma_ctrl
// Sequencer: steps the datapath through one request and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pcma_ctrl (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire pcma_pkg::sts_t sts,
    output pcma_pkg::cmd_t cmd
);

    pcma_pkg::state_t state_reg, state_next;
    pcma_pkg::term_t  term_reg, term_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            pcma_pkg::ST_IDLE:    if (s_valid) state_next = pcma_pkg::ST_ERR;
            pcma_pkg::ST_ERR: begin
                state_next = pcma_pkg::ST_INTEG;
                term_next  = pcma_pkg::TERM_P;
            end
            pcma_pkg::ST_INTEG:   state_next = pcma_pkg::ST_OPND;
            pcma_pkg::ST_OPND:    state_next = pcma_pkg::ST_MUL_LO;
            pcma_pkg::ST_MUL_LO:  state_next = pcma_pkg::ST_MUL_HI;
            pcma_pkg::ST_MUL_HI:  state_next = pcma_pkg::ST_MAG;
            pcma_pkg::ST_MAG:     state_next = pcma_pkg::ST_ACC;
            pcma_pkg::ST_ACC: begin
                case (term_reg)
                    pcma_pkg::TERM_P: begin
                        term_next  = pcma_pkg::TERM_I;
                        state_next = pcma_pkg::ST_OPND;
                    end
                    pcma_pkg::TERM_I: begin
                        term_next  = pcma_pkg::TERM_D;
                        state_next = pcma_pkg::ST_OPND;
                    end
                    default: state_next = pcma_pkg::ST_CLAMP;
                endcase
            end
            pcma_pkg::ST_CLAMP:   state_next = pcma_pkg::ST_WRITE;
            pcma_pkg::ST_WRITE:   state_next = pcma_pkg::ST_SUM;
            pcma_pkg::ST_SUM:     if (sts.sum_last) state_next = pcma_pkg::ST_DIV_SET;
            pcma_pkg::ST_DIV_SET: state_next = pcma_pkg::ST_DIV;
            pcma_pkg::ST_DIV:     if (sts.div_last) state_next = pcma_pkg::ST_DONE;
            pcma_pkg::ST_DONE:    if (out_free) state_next = pcma_pkg::ST_IDLE;
            default:              state_next = pcma_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        cmd.term = term_reg;
        s_ready  = 1'b0;
        case (state_reg)
            pcma_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            pcma_pkg::ST_ERR:     cmd.calc_err   = 1'b1;
            pcma_pkg::ST_INTEG:   cmd.calc_integ = 1'b1;
            pcma_pkg::ST_OPND:    cmd.load_opnd  = 1'b1;
            pcma_pkg::ST_MUL_LO:  cmd.mul_lo     = 1'b1;
            pcma_pkg::ST_MUL_HI:  cmd.mul_hi     = 1'b1;
            pcma_pkg::ST_MAG:     cmd.calc_mag   = 1'b1;
            pcma_pkg::ST_ACC:     cmd.accum      = 1'b1;
            pcma_pkg::ST_CLAMP:   cmd.clamp      = 1'b1;
            pcma_pkg::ST_WRITE:   cmd.ring_write = 1'b1;
            pcma_pkg::ST_SUM:     cmd.sum_step   = 1'b1;
            pcma_pkg::ST_DIV_SET: cmd.div_set    = 1'b1;
            pcma_pkg::ST_DIV:     cmd.div_step   = 1'b1;
            pcma_pkg::ST_DONE:    cmd.load_out   = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pcma_pkg::ST_IDLE;
            term_reg    <= pcma_pkg::TERM_P;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            term_reg    <= term_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while previous result pending");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == pcma_pkg::ST_ERR))
        else $error("accepted request did not start the sequence");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != pcma_pkg::ST_IDLE) |-> !s_ready)
        else $error("input ready while a request is in flight");

    a_three_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcma_pkg::ST_ACC && term_reg == pcma_pkg::TERM_D)
        |=> (state_reg == pcma_pkg::ST_CLAMP))
        else $error("clamp not reached after derivative term");

endmodule

`default_nettype wire

[rtl/pcma_dp.sv]
// ----------------------------------------------------------------------------
// pcma_dp
// Datapath: error, integrator, shared multiplier, clamp, ring, sum and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pcma_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire pcma_pkg::cfg_t cfg,
    input  wire pcma_pkg::cmd_t cmd,
    output pcma_pkg::sts_t     sts,
    input  wire logic [31:0]   s_measurement,
    output logic [31:0]        m_drive,
    output logic [31:0]        m_averaged_drive
);

    localparam int IDX_W     = pcma_pkg::IDX_W;
    localparam int LEN_W     = pcma_pkg::LEN_W;
    localparam int SUM_W     = pcma_pkg::SUM_W;
    localparam int DIV_W     = pcma_pkg::DIV_W;
    localparam int DIV_CNT_W = pcma_pkg::DIV_CNT_W;

    // state with defined reset
    logic signed [47:0] integ_reg;
    logic signed [31:0] prev_reg;
    logic signed [31:0] hist_reg [pcma_pkg::MAX_WINDOW];
    logic [IDX_W-1:0]   wp_reg;

    // working registers
    logic signed [31:0] meas_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] delta_reg;
    logic [48:0]        ua_reg;
    logic [31:0]        ub_reg;
    logic               neg_reg;
    logic [63:0]        pp_lo_reg;
    logic [48:0]        pp_hi_reg;
    logic [63:0]        q_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] drive_reg;
    logic [IDX_W-1:0]   sum_idx_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic               sneg_reg;
    logic [31:0]        m_drive_reg;
    logic [31:0]        m_avg_reg;

    // combinational values
    logic [LEN_W-1:0]   len_c;
    logic signed [32:0] diff_c;
    logic signed [31:0] err_c;
    logic signed [48:0] isum_c;
    logic signed [47:0] integ_c;
    logic signed [32:0] delta_c;
    logic [48:0]        a_c;
    logic [31:0]        b_c;
    logic [48:0]        ua_c;
    logic [31:0]        ub_c;
    logic [64:0]        mag_c;
    logic [63:0]        qc_c;
    logic signed [63:0] term_c;
    logic signed [63:0] upper_c;
    logic signed [63:0] lower_c;
    logic signed [31:0] drive_c;
    logic [IDX_W-1:0]   wp_eff_c;
    logic [LEN_W-1:0]   wp_inc_c;
    logic [IDX_W-1:0]   wp_next_c;
    logic [SUM_W-1:0]   sum_abs_c;
    logic [LEN_W:0]     div_r;
    logic               div_ge;
    logic [LEN_W-1:0]   rem_next;
    logic [DIV_W-1:0]   quo_next;
    logic [31:0]        avg_c;

    // effective window: 0 counts as 1, oversize clamps to the ring depth
    always_comb begin
        if (cfg.window_length == 5'd0)
            len_c = LEN_W'(1);
        else if (int'(cfg.window_length) > pcma_pkg::MAX_WINDOW)
            len_c = LEN_W'(pcma_pkg::MAX_WINDOW);
        else
            len_c = LEN_W'(cfg.window_length);
    end

    // error and integrator, both saturating
    always_comb begin
        diff_c = {cfg.setpoint[31], cfg.setpoint} - {meas_reg[31], meas_reg};
        if (diff_c[32] != diff_c[31])
            err_c = diff_c[32] ? pcma_pkg::INT32_MIN : pcma_pkg::INT32_MAX;
        else
            err_c = diff_c[31:0];

        isum_c = {integ_reg[47], integ_reg} + {{17{err_reg[31]}}, err_reg};
        if (isum_c[48] != isum_c[47])
            integ_c = isum_c[48] ? pcma_pkg::INT48_MIN : pcma_pkg::INT48_MAX;
        else
            integ_c = isum_c[47:0];

        delta_c = {err_reg[31], err_reg} - {prev_reg[31], prev_reg};
    end

    // operand select for the shared multiplier, sign-magnitude form
    always_comb begin
        case (cmd.term)
            pcma_pkg::TERM_P: begin
                a_c = {{17{err_reg[31]}}, err_reg};
                b_c = cfg.kp;
            end
            pcma_pkg::TERM_I: begin
                a_c = {integ_reg[47], integ_reg};
                b_c = cfg.ki_scaled;
            end
            pcma_pkg::TERM_D: begin
                a_c = {{16{delta_reg[32]}}, delta_reg};
                b_c = cfg.kd_scaled;
            end
            default: begin
                a_c = '0;
                b_c = '0;
            end
        endcase
        ua_c = a_c[48] ? (49'd0 - a_c) : a_c;
        ub_c = b_c[31] ? (32'd0 - b_c) : b_c;
    end

    // |a*b| >> 16, rounded up for negative products so the signed result floors
    always_comb begin
        mag_c  = {pp_hi_reg, 16'd0} + 65'(pp_lo_reg[63:16])
               + 65'(neg_reg & (|pp_lo_reg[15:0]));
        qc_c   = (q_reg > pcma_pkg::TERM_LIMIT) ? pcma_pkg::TERM_LIMIT : q_reg;
        term_c = neg_reg ? -$signed(qc_c) : $signed(qc_c);
    end

    // clamp: upper bound wins
    always_comb begin
        upper_c = {{32{cfg.clamp_hi[31]}}, cfg.clamp_hi};
        lower_c = {{32{cfg.clamp_lo[31]}}, cfg.clamp_lo};
        if (acc_reg > upper_c)
            drive_c = cfg.clamp_hi;
        else if (acc_reg < lower_c)
            drive_c = cfg.clamp_lo;
        else
            drive_c = acc_reg[31:0];
    end

    // ring position; a shrunk window restarts at entry 0
    always_comb begin
        wp_eff_c  = (LEN_W'(wp_reg) >= len_c) ? '0 : wp_reg;
        wp_inc_c  = LEN_W'(wp_eff_c) + LEN_W'(1);
        wp_next_c = (wp_inc_c >= len_c) ? '0 : wp_inc_c[IDX_W-1:0];
    end

    assign sum_abs_c = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;

    // four restoring steps per cycle; remainder stays below the window
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_r    = '0;
        div_ge   = 1'b0;
        for (int k = 0; k < pcma_pkg::DIV_STEPS; k++) begin
            div_r    = {rem_next, quo_next[DIV_W-1]};
            div_ge   = div_r >= {1'b0, len_c};
            rem_next = div_ge ? LEN_W'(div_r - {1'b0, len_c}) : div_r[LEN_W-1:0];
            quo_next = {quo_next[DIV_W-2:0], div_ge};
        end
    end

    assign avg_c = sneg_reg ? (32'd0 - quo_reg[31:0]) : quo_reg[31:0];

    assign sts.sum_last = (LEN_W'(sum_idx_reg) + LEN_W'(1)) == len_c;
    assign sts.div_last = div_cnt_reg == DIV_CNT_W'(pcma_pkg::DIV_CYC - 1);

    // persistent controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_reg  <= '0;
            wp_reg    <= '0;
            for (int i = 0; i < pcma_pkg::MAX_WINDOW; i++)
                hist_reg[i] <= '0;
        end else begin
            if (cmd.calc_integ) begin
                integ_reg <= integ_c;
                prev_reg  <= err_reg;
            end
            if (cmd.ring_write) begin
                hist_reg[wp_eff_c] <= drive_reg;
                wp_reg             <= wp_next_c;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture)
            meas_reg <= s_measurement;
        if (cmd.calc_err) begin
            err_reg <= err_c;
            acc_reg <= {{32{cfg.output_offset[31]}}, cfg.output_offset};
        end
        if (cmd.calc_integ)
            delta_reg <= delta_c;
        if (cmd.load_opnd) begin
            ua_reg  <= ua_c;
            ub_reg  <= ub_c;
            neg_reg <= a_c[48] ^ b_c[31];
        end
        if (cmd.mul_lo)
            pp_lo_reg <= ua_reg[31:0] * ub_reg;
        if (cmd.mul_hi)
            pp_hi_reg <= 49'(ua_reg[48:32]) * 49'(ub_reg);
        if (cmd.calc_mag)
            q_reg <= mag_c[63:0];
        if (cmd.accum)
            acc_reg <= acc_reg + term_c;
        if (cmd.clamp)
            drive_reg <= drive_c;
        if (cmd.ring_write) begin
            sum_reg     <= '0;
            sum_idx_reg <= '0;
        end
        if (cmd.sum_step) begin
            sum_reg     <= sum_reg + {{IDX_W{hist_reg[sum_idx_reg][31]}},
                                      hist_reg[sum_idx_reg]};
            sum_idx_reg <= sum_idx_reg + IDX_W'(1);
        end
        if (cmd.div_set) begin
            sneg_reg    <= sum_reg[SUM_W-1];
            quo_reg     <= DIV_W'(sum_abs_c);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.load_out) begin
            m_drive_reg <= drive_reg;
            m_avg_reg   <= avg_c;
        end
    end

    assign m_drive          = m_drive_reg;
    assign m_averaged_drive = m_avg_reg;

endmodule

`default_nettype wire

[rtl/pid_clamp_moving_average_core.sv]
// ----------------------------------------------------------------------------
// pid_clamp_moving_average_core
// Fixed-point PID with output clamp and moving-average filter, Q16.16.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------
//   input     s_valid / s_ready    s_measurement[31:0]
//   result    m_valid / m_ready    m_drive[31:0], m_averaged_drive[31:0]
//   config    cfg_we (no wait)     cfg_addr[3:0], cfg_wdata[31:0]
//
// One request at a time: the next request is accepted only after the sequencer
// returns to idle. The effective window is 1 to 16 entries. Each gain product takes
// a 32x32 low-half and a 17x32 high-half multiply in separate cycles, the ring
// is summed one entry per cycle and the mean comes from a divider producing
// four bits per cycle.
// Reset clears the integrator, previous error, ring entries and write pointer.
// A result waiting on m_ready holds the sequencer in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_clamp_moving_average_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [31:0]                      s_measurement,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [31:0]                           m_drive,
    output logic [31:0]                           m_averaged_drive,
    input  wire logic                             cfg_we,
    input  wire logic [pcma_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pcma_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    pcma_pkg::cfg_t cfg;
    pcma_pkg::cmd_t cmd;
    pcma_pkg::sts_t sts;

    pcma_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pcma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcma_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .cmd              (cmd),
        .sts              (sts),
        .s_measurement    (s_measurement),
        .m_drive          (m_drive),
        .m_averaged_drive (m_averaged_drive)
    );

endmodule

`default_nettype wire
